>>> rtl/nvd_pkg.sv
// Shared types, constants and elaboration-time helpers for the diffusion pixel update.
// Used by every module in rtl/. Depends on nothing else.
package nvd_pkg;

    // Field widths
    localparam int PIX_W    = 8;
    localparam int GRAD_W   = PIX_W + 1;     // neighbour minus centre
    localparam int CROSS_W  = PIX_W + 3;     // sum of two minus sum of two
    localparam int SUM_W    = 21;            // 16*g^2 + x^2
    localparam int LOG_N_W  = 6;             // integer part of log2
    localparam int FRAC_W   = 16;            // fraction bits of log2 and exponent
    localparam int MANT_W   = 31;            // Q30 mantissa in [1,2)
    localparam int DIFF_W   = 64;            // diffusivity word
    localparam int WGT_W    = 17;            // Q1.16 pair weight
    localparam int OUT_T_W  = 15;            // blended sum divided by 2^17

    // Arithmetic constants
    localparam int EPS_Q16    = 164;         // 0.0025 in Q16
    localparam int EPS_MSB    = 7;           // top bit of EPS_Q16
    localparam int GRAD_SHIFT = 12;          // sixteenths to Q16
    localparam int POW_Q16    = 62259;       // 0.95 in Q16
    localparam int EXP_CAP    = 32;          // largest shift of the mantissa
    localparam int WSUM_Q16   = 131072;      // a pair of weights sums to 2.0
    localparam int HALF_WGT   = 65536;       // weight 1.0 when both diffusivities vanish
    localparam int MIX_C      = 27;          // centre share, scaled
    localparam int MIX_F      = 3;           // noisy share, scaled
    localparam int MIX_W      = 5;           // neighbour share, scaled
    localparam int RECIP_25   = 5243;        // 2^17/25, rounded up
    localparam int OUT_MAX    = 255;

    // Pipeline depths
    localparam int DIFF_LAT  = 37;
    localparam int DIV_LAT   = 18;
    localparam int BLEND_LAT = 3;
    localparam int DLY_DEPTH = DIFF_LAT + DIV_LAT;
    localparam int PIPE_LAST = DLY_DEPTH + BLEND_LAT;

    // One input word as captured at the front of the pipeline
    typedef struct packed {
        logic [PIX_W-1:0] center;
        logic [PIX_W-1:0] north;
        logic [PIX_W-1:0] south;
        logic [PIX_W-1:0] west;
        logic [PIX_W-1:0] east;
        logic [PIX_W-1:0] north_west;
        logic [PIX_W-1:0] north_east;
        logic [PIX_W-1:0] south_west;
        logic [PIX_W-1:0] south_east;
        logic [PIX_W-1:0] noisy_center;
    } t_hood;

    // Pixels still needed by the final blend
    typedef struct packed {
        logic [PIX_W-1:0] center;
        logic [PIX_W-1:0] north;
        logic [PIX_W-1:0] south;
        logic [PIX_W-1:0] west;
        logic [PIX_W-1:0] east;
        logic [PIX_W-1:0] noisy_center;
    } t_pix;

    // Integer floor square root, evaluated at elaboration only.
    function automatic logic [63:0] f_isqrt(input logic [63:0] v);
        logic [63:0] res;
        logic [63:0] sq_bit;
        logic [63:0] rem;
        res    = '0;
        sq_bit = 64'd1 << 62;
        rem    = v;
        for (int i = 0; i < 32; i++) begin
            if (rem >= res + sq_bit) begin
                rem = rem - (res + sq_bit);
                res = (res >> 1) + sq_bit;
            end else begin
                res = res >> 1;
            end
            sq_bit = sq_bit >> 2;
        end
        return res;
    endfunction

    // 2^(2^-(idx+1)) in Q30, each root taken from the one before.
    function automatic logic [63:0] f_root(input int idx);
        logic [63:0] r;
        r = f_isqrt(64'd2 << 60);
        for (int j = 1; j < FRAC_W; j++) begin
            if (j <= idx) begin
                r = f_isqrt(r << 30);
            end
        end
        return r;
    endfunction

endpackage

>>> rtl/nvd_diffusivity.sv
// Diffusivity of one half-point: (eps + g^2 + (x/4)^2)^0.95 as exp2(0.95*log2).
// Fixed 37-stage pipeline with a common advance enable. Depends on nvd_pkg.
module nvd_diffusivity (
    input  logic                                 i_clk,
    input  logic                                 i_en,
    input  logic signed [nvd_pkg::GRAD_W-1:0]    i_grad,
    input  logic signed [nvd_pkg::CROSS_W-1:0]   i_cross,
    output logic        [nvd_pkg::DIFF_W-1:0]    o_diff
);
    import nvd_pkg::*;

    localparam int V_W    = SUM_W + GRAD_SHIFT;
    localparam int WIDE_W = V_W + 32;

    logic signed [2*GRAD_W-1:0]  w_g2;
    logic signed [2*CROSS_W-1:0] w_x2;
    logic [SUM_W-1:0]            r_s16;
    logic [SUM_W-1:0]            r_s16b;
    logic [LOG_N_W-1:0]          n_top;
    logic [LOG_N_W-1:0]          r_nb;
    logic [V_W-1:0]              w_v;
    logic [WIDE_W-1:0]           w_wide;

    logic [MANT_W-1:0]  r_m    [FRAC_W+1];
    logic [FRAC_W-1:0]  r_frac [FRAC_W+1];
    logic [LOG_N_W-1:0] r_nq   [FRAC_W+1];

    logic [LOG_N_W+FRAC_W-1:0]    w_log;
    logic [LOG_N_W+FRAC_W+15:0]   w_e;
    logic [LOG_N_W-1:0]           w_kraw;

    logic [MANT_W-1:0]  r_acc [FRAC_W+1];
    logic [FRAC_W-1:0]  r_f   [FRAC_W+1];
    logic [LOG_N_W-1:0] r_k   [FRAC_W+1];
    logic [DIFF_W-1:0]  r_d;

    // Gradient energy in sixteenths.
    assign w_g2 = i_grad * i_grad;
    assign w_x2 = i_cross * i_cross;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s16 <= SUM_W'({w_g2[15:0], 4'b0000}) + SUM_W'(w_x2[17:0]);
        end
    end

    // Position of the top bit of the argument; eps alone sets it when flat.
    always_comb begin
        n_top = LOG_N_W'(EPS_MSB);
        for (int i = 0; i < SUM_W; i++) begin
            if (r_s16[i]) begin
                n_top = LOG_N_W'(i + GRAD_SHIFT);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s16b <= r_s16;
            r_nb   <= n_top;
        end
    end

    // Normalise the argument to a Q30 mantissa in [1,2).
    assign w_v    = {r_s16b, GRAD_SHIFT'(0)} | V_W'(EPS_Q16);
    assign w_wide = {w_v, 32'd0} >> (7'(r_nb) + 7'd2);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_m[0]    <= w_wide[MANT_W-1:0];
            r_frac[0] <= '0;
            r_nq[0]   <= r_nb;
        end
    end

    // log2 fraction: one squaring per stage yields one bit.
    for (genvar s = 0; s < FRAC_W; s++) begin : g_sq
        logic [2*MANT_W-1:0] w_p;
        logic [MANT_W:0]     w_t;
        assign w_p = (2*MANT_W)'(r_m[s]) * (2*MANT_W)'(r_m[s]);
        assign w_t = w_p[2*MANT_W-1:MANT_W-1];
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_m[s+1]    <= w_t[MANT_W] ? w_t[MANT_W:1] : w_t[MANT_W-1:0];
                r_frac[s+1] <= {r_frac[s][FRAC_W-2:0], w_t[MANT_W]};
                r_nq[s+1]   <= r_nq[s];
            end
        end
    end

    // Scale the logarithm by 0.95 and split into shift and fraction.
    assign w_log  = {r_nq[FRAC_W], r_frac[FRAC_W]};
    assign w_e    = (LOG_N_W+FRAC_W+16)'(w_log) * (LOG_N_W+FRAC_W+16)'(POW_Q16);
    assign w_kraw = w_e[LOG_N_W+FRAC_W+15:2*FRAC_W];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_acc[0] <= MANT_W'(1) << (MANT_W-1);
            r_f[0]   <= w_e[2*FRAC_W-1:FRAC_W];
            r_k[0]   <= (w_kraw > LOG_N_W'(EXP_CAP)) ? LOG_N_W'(EXP_CAP) : w_kraw;
        end
    end

    // exp2 of the fraction: one conditional root multiply per stage.
    for (genvar i = 0; i < FRAC_W; i++) begin : g_exp
        localparam logic [MANT_W-1:0] ROOT = MANT_W'(f_root(i));
        logic [2*MANT_W-1:0] w_p;
        assign w_p = (2*MANT_W)'(r_acc[i]) * (2*MANT_W)'(ROOT);
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_acc[i+1] <= r_f[i][FRAC_W-1-i] ? w_p[2*MANT_W-2:MANT_W-1] : r_acc[i];
                r_f[i+1]   <= r_f[i];
                r_k[i+1]   <= r_k[i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_d <= DIFF_W'(r_acc[FRAC_W]) << r_k[FRAC_W];
        end
    end

    assign o_diff = r_d;

endmodule

>>> rtl/nvd_pair_divider.sv
// Pair weight floor(2^17 * d_other / (d_this + d_other)) by restoring division.
// One sum stage and seventeen quotient stages, 18 in all. Depends on nvd_pkg.
module nvd_pair_divider (
    input  logic                          i_clk,
    input  logic                          i_en,
    input  logic [nvd_pkg::DIFF_W-1:0]    i_d_this,
    input  logic [nvd_pkg::DIFF_W-1:0]    i_d_other,
    output logic [nvd_pkg::WGT_W-1:0]     o_weight
);
    import nvd_pkg::*;

    logic [DIFF_W-1:0] w_sum;
    logic [DIFF_W-1:0] r_sum  [WGT_W+1];
    logic [DIFF_W-1:0] r_rem  [WGT_W+1];
    logic [WGT_W-1:0]  r_q    [WGT_W+1];
    logic              r_zero [WGT_W+1];

    assign w_sum = i_d_this + i_d_other;

    // Divisor and starting remainder.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sum[0]  <= w_sum;
            r_rem[0]  <= i_d_other;
            r_q[0]    <= '0;
            r_zero[0] <= (w_sum == '0);
        end
    end

    // One quotient bit per stage.
    for (genvar k = 0; k < WGT_W; k++) begin : g_step
        logic [DIFF_W-1:0] w_rem2;
        logic              w_ge;
        assign w_rem2 = r_rem[k] << 1;
        assign w_ge   = (w_rem2 >= r_sum[k]);
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k+1]  <= w_ge ? (w_rem2 - r_sum[k]) : w_rem2;
                r_q[k+1]    <= {r_q[k][WGT_W-2:0], w_ge};
                r_sum[k+1]  <= r_sum[k];
                r_zero[k+1] <= r_zero[k];
            end
        end
    end

    // Both diffusivities zero: equal weights.
    assign o_weight = r_zero[WGT_W] ? WGT_W'(HALF_WGT) : r_q[WGT_W];

endmodule

>>> rtl/nvd_blend.sv
// Final blend: weighted neighbours, centre and noisy pixel, scaled by 1/3276800.
// Three register stages with a common advance enable. Depends on nvd_pkg.
module nvd_blend (
    input  logic                          i_clk,
    input  logic                          i_en,
    input  logic [nvd_pkg::WGT_W-1:0]     i_w_south,
    input  logic [nvd_pkg::WGT_W-1:0]     i_w_east,
    input  nvd_pkg::t_pix                 i_pix,
    output logic [nvd_pkg::PIX_W-1:0]     o_value
);
    import nvd_pkg::*;

    localparam int PROD_W = WGT_W + 1 + PIX_W;
    localparam int BASE_W = 13;
    localparam int ACC_W  = 32;
    localparam int Q_W    = OUT_T_W + 13;

    logic [WGT_W:0]    w_a_n;
    logic [WGT_W:0]    w_a_w;
    logic [PROD_W-1:0] r_p_s;
    logic [PROD_W-1:0] r_p_n;
    logic [PROD_W-1:0] r_p_e;
    logic [PROD_W-1:0] r_p_w;
    logic [BASE_W-1:0] r_base;
    logic [ACC_W-1:0]  w_r;
    logic [OUT_T_W-1:0] r_t;
    logic [Q_W-1:0]    w_q;
    logic [Q_W-18:0]   w_quo;
    logic [PIX_W-1:0]  r_value;

    // Partner weights make each pair sum to 2.0.
    assign w_a_n = (WGT_W+1)'(WSUM_Q16) - (WGT_W+1)'(i_w_south);
    assign w_a_w = (WGT_W+1)'(WSUM_Q16) - (WGT_W+1)'(i_w_east);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p_s  <= PROD_W'(i_w_south) * PROD_W'(i_pix.south);
            r_p_n  <= PROD_W'(w_a_n) * PROD_W'(i_pix.north);
            r_p_e  <= PROD_W'(i_w_east) * PROD_W'(i_pix.east);
            r_p_w  <= PROD_W'(w_a_w) * PROD_W'(i_pix.west);
            r_base <= BASE_W'(MIX_C) * BASE_W'(i_pix.center)
                    + BASE_W'(MIX_F) * BASE_W'(i_pix.noisy_center);
        end
    end

    // Full numerator, then drop the power-of-two part of the divisor.
    assign w_r = (ACC_W'(r_base) << 16)
               + ACC_W'(MIX_W) * (ACC_W'(r_p_s) + ACC_W'(r_p_n)
                                + ACC_W'(r_p_e) + ACC_W'(r_p_w));

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_t <= w_r[ACC_W-1:17];
        end
    end

    // Divide by 25 through the reciprocal; exact over the whole range of r_t.
    assign w_q   = Q_W'(r_t) * Q_W'(RECIP_25);
    assign w_quo = w_q[Q_W-1:17];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_value <= (w_quo > (Q_W-17)'(OUT_MAX)) ? PIX_W'(OUT_MAX) : w_quo[PIX_W-1:0];
        end
    end

    assign o_value = r_value;

endmodule

>>> rtl/nonconvex_diffusion_pixel_update_unit.sv
// Top level of the nonconvex diffusion pixel update: capture, diffusivities, weights, blend.
// Depends on nvd_pkg, nvd_diffusivity, nvd_pair_divider and nvd_blend.
//
//  channel | direction | handshake          | word
//  --------+-----------+--------------------+-------------------------------------------
//  input   | in        | i_valid / o_ready  | i_center .. i_south_east, i_noisy_center
//  output  | out       | o_valid / i_ready  | o_updated_value
//
// One word is taken every cycle while the output word is not held.
// Most of the depth is the 16-step log2 squaring chain, the 16-step exp2 multiply chain
// and the 17-step weight division, one step per register stage.
// Synchronous active-low reset clears the valid bits only; data registers are not reset.
// When the output word is held and not taken, the whole pipeline holds; nothing is lost.
module nonconvex_diffusion_pixel_update_unit (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic [nvd_pkg::PIX_W-1:0]    i_center,
    input  logic [nvd_pkg::PIX_W-1:0]    i_north,
    input  logic [nvd_pkg::PIX_W-1:0]    i_south,
    input  logic [nvd_pkg::PIX_W-1:0]    i_west,
    input  logic [nvd_pkg::PIX_W-1:0]    i_east,
    input  logic [nvd_pkg::PIX_W-1:0]    i_north_west,
    input  logic [nvd_pkg::PIX_W-1:0]    i_north_east,
    input  logic [nvd_pkg::PIX_W-1:0]    i_south_west,
    input  logic [nvd_pkg::PIX_W-1:0]    i_south_east,
    input  logic [nvd_pkg::PIX_W-1:0]    i_noisy_center,
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic [nvd_pkg::PIX_W-1:0]    o_updated_value
);
    import nvd_pkg::*;

    logic               w_adv;
    logic [PIPE_LAST:0] r_vld;
    t_hood              r_hood;
    t_pix               r_dly [DLY_DEPTH];

    logic signed [GRAD_W-1:0]  w_g_s, w_g_n, w_g_e, w_g_w;
    logic signed [CROSS_W-1:0] w_x_s, w_x_n, w_x_e, w_x_w;
    logic signed [CROSS_W-1:0] w_se, w_e, w_sw, w_w, w_ne, w_nw, w_s, w_n;
    logic [DIFF_W-1:0] w_d_s, w_d_n, w_d_e, w_d_w;
    logic [WGT_W-1:0]  w_a_s, w_a_e;

    // The pipeline moves unless the output word is waiting to be taken.
    assign w_adv   = !r_vld[PIPE_LAST] || i_ready;
    assign o_ready = w_adv;
    assign o_valid = r_vld[PIPE_LAST];

    // Valid bits travel alongside the data.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_adv) begin
            r_vld <= {r_vld[PIPE_LAST-1:0], i_valid};
        end
    end

    // Input capture.
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_hood <= '{center: i_center, north: i_north, south: i_south, west: i_west,
                        east: i_east, north_west: i_north_west, north_east: i_north_east,
                        south_west: i_south_west, south_east: i_south_east,
                        noisy_center: i_noisy_center};
        end
    end

    // Pixels wait here while the weights are computed.
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_dly[0] <= '{center: r_hood.center, north: r_hood.north, south: r_hood.south,
                          west: r_hood.west, east: r_hood.east,
                          noisy_center: r_hood.noisy_center};
            for (int i = 1; i < DLY_DEPTH; i++) begin
                r_dly[i] <= r_dly[i-1];
            end
        end
    end

    // Gradients towards each half-point and the cross-differences along the other axis.
    assign w_g_s = $signed({1'b0, r_hood.south}) - $signed({1'b0, r_hood.center});
    assign w_g_n = $signed({1'b0, r_hood.north}) - $signed({1'b0, r_hood.center});
    assign w_g_e = $signed({1'b0, r_hood.east})  - $signed({1'b0, r_hood.center});
    assign w_g_w = $signed({1'b0, r_hood.west})  - $signed({1'b0, r_hood.center});

    assign w_se = $signed(CROSS_W'(r_hood.south_east));
    assign w_sw = $signed(CROSS_W'(r_hood.south_west));
    assign w_ne = $signed(CROSS_W'(r_hood.north_east));
    assign w_nw = $signed(CROSS_W'(r_hood.north_west));
    assign w_e  = $signed(CROSS_W'(r_hood.east));
    assign w_w  = $signed(CROSS_W'(r_hood.west));
    assign w_s  = $signed(CROSS_W'(r_hood.south));
    assign w_n  = $signed(CROSS_W'(r_hood.north));

    assign w_x_s = w_se + w_e - w_sw - w_w;
    assign w_x_n = w_ne + w_e - w_nw - w_w;
    assign w_x_e = w_se + w_s - w_ne - w_n;
    assign w_x_w = w_sw + w_s - w_nw - w_n;

    nvd_diffusivity u_diff_s (
        .i_clk(i_clk), .i_en(w_adv), .i_grad(w_g_s), .i_cross(w_x_s), .o_diff(w_d_s)
    );
    nvd_diffusivity u_diff_n (
        .i_clk(i_clk), .i_en(w_adv), .i_grad(w_g_n), .i_cross(w_x_n), .o_diff(w_d_n)
    );
    nvd_diffusivity u_diff_e (
        .i_clk(i_clk), .i_en(w_adv), .i_grad(w_g_e), .i_cross(w_x_e), .o_diff(w_d_e)
    );
    nvd_diffusivity u_diff_w (
        .i_clk(i_clk), .i_en(w_adv), .i_grad(w_g_w), .i_cross(w_x_w), .o_diff(w_d_w)
    );

    // Vertical and horizontal pair weights.
    nvd_pair_divider u_div_ns (
        .i_clk(i_clk), .i_en(w_adv), .i_d_this(w_d_s), .i_d_other(w_d_n), .o_weight(w_a_s)
    );
    nvd_pair_divider u_div_ew (
        .i_clk(i_clk), .i_en(w_adv), .i_d_this(w_d_e), .i_d_other(w_d_w), .o_weight(w_a_e)
    );

    nvd_blend u_blend (
        .i_clk     (i_clk),
        .i_en      (w_adv),
        .i_w_south (w_a_s),
        .i_w_east  (w_a_e),
        .i_pix     (r_dly[DLY_DEPTH-1]),
        .o_value   (o_updated_value)
    );

    // A result can only appear after the stage before it held a word, or by holding.
    a_out_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ($past(r_vld[PIPE_LAST-1]) || $past(o_valid)))
        else $error("result word appeared without a word behind it");

    // A held pipeline keeps every valid bit in place.
    a_hold_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_adv |=> $stable(r_vld))
        else $error("valid bits moved while the pipeline was held");

    // The front stage records exactly whether a word was accepted.
    a_front_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ready |=> (r_vld[0] == $past(i_valid)))
        else $error("front valid bit disagrees with the input handshake");

    // Reset empties the output.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid after reset");

endmodule

>>> dv/nvd_update_checker.sv
// Checker for the diffusion pixel update: watches both channels, predicts each updated pixel
// and compares it with the block's output. Depends on nvd_pkg only.
module nvd_update_checker (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    input  logic                      i_in_ready,
    input  nvd_pkg::t_hood            i_hood,
    input  logic                      i_out_valid,
    input  logic                      i_ready,
    input  logic [nvd_pkg::PIX_W-1:0] i_updated_value,
    output int                        o_fail_count,
    output int                        o_pending
);
    timeunit 1ns;
    timeprecision 1ps;
    import nvd_pkg::*;

    logic [PIX_W-1:0] expected_pixels[$];
    logic [63:0]      exp2_roots[FRAC_W];
    int               fail_count = 0;

    assign o_fail_count = fail_count;
    assign o_pending    = expected_pixels.size();

    // Floor square root, used to build the fractional power table.
    function automatic logic [63:0] floor_sqrt(input logic [63:0] v);
        logic [63:0] res;
        logic [63:0] bitv;
        res  = '0;
        bitv = 64'd1 << 62;
        while (bitv > v) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (v >= res + bitv) begin
                v   = v - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    initial begin
        exp2_roots[0] = floor_sqrt(64'd2 << 60);
        for (int i = 1; i < FRAC_W; i++) exp2_roots[i] = floor_sqrt(exp2_roots[i-1] << 30);
    end

    // Diffusivity scaled by a common factor: 2^(0.95*log2(16g^2 + x^2 scaled, plus epsilon)).
    function automatic logic [63:0] edge_diffusivity(input int g, input int x);
        logic [63:0] arg;
        logic [63:0] mant;
        logic [63:0] lg;
        logic [63:0] ex;
        logic [63:0] acc;
        logic [63:0] shift;
        int          msb;
        arg = ((64'(16 * g * g) + 64'(x * x)) << GRAD_SHIFT) + EPS_Q16;
        msb = 0;
        while (msb < 63 && (arg >> (msb + 1)) != 0) msb++;
        mant = (msb <= 30) ? (arg << (30 - msb)) : (arg >> (msb - 30));
        lg = '0;
        for (int i = 0; i < FRAC_W; i++) begin
            mant = (mant * mant) >> 30;
            lg   = lg << 1;
            if (mant >= (64'd1 << 31)) begin
                mant = mant >> 1;
                lg   = lg | 1;
            end
        end
        lg    = lg | (64'(msb) << 16);
        ex    = (lg * POW_Q16) >> 16;
        shift = ex >> 16;
        acc   = 64'd1 << 30;
        for (int i = 0; i < FRAC_W; i++)
            if (ex[15 - i]) acc = (acc * exp2_roots[i]) >> 30;
        if (shift > EXP_CAP) shift = EXP_CAP;
        return acc << shift;
    endfunction

    // Q1.16 share of one side of an opposite pair.
    function automatic logic [63:0] side_weight(input logic [63:0] d_this,
                                                input logic [63:0] d_other);
        logic [63:0] total;
        logic [63:0] rem;
        logic [63:0] q;
        total = d_this + d_other;
        if (total == 0) return HALF_WGT;
        rem = d_other;
        q   = '0;
        for (int i = 0; i < WGT_W; i++) begin
            rem = rem << 1;
            q   = q << 1;
            if (rem >= total) begin
                rem = rem - total;
                q   = q | 1;
            end
        end
        return q;
    endfunction

    function automatic logic [PIX_W-1:0] predict_update(input t_hood h);
        int          c, n, s, w, e, nw, ne, sw, se, f;
        logic [63:0] d_s, d_n, d_e, d_w, a_s, a_n, a_e, a_w, mix, v;
        c = h.center; n = h.north; s = h.south; w = h.west; e = h.east;
        nw = h.north_west; ne = h.north_east; sw = h.south_west; se = h.south_east;
        f = h.noisy_center;
        d_s = edge_diffusivity(s - c, se + e - sw - w);
        d_n = edge_diffusivity(n - c, ne + e - nw - w);
        d_e = edge_diffusivity(e - c, se + s - ne - n);
        d_w = edge_diffusivity(w - c, sw + s - nw - n);
        a_s = side_weight(d_s, d_n);
        a_n = WSUM_Q16 - a_s;
        a_e = side_weight(d_e, d_w);
        a_w = WSUM_Q16 - a_e;
        mix = 64'd65536 * 64'(MIX_C * c + MIX_F * f)
            + MIX_W * (a_s * s + a_n * n + a_e * e + a_w * w);
        v = mix / 64'd3276800;
        if (v > OUT_MAX) v = OUT_MAX;
        return v[PIX_W-1:0];
    endfunction

    // Predict on each accepted input word and check each accepted output word.
    always @(posedge i_clk) begin
        logic [PIX_W-1:0] want;
        if (i_rst_n) begin
            if (i_valid && i_in_ready) expected_pixels.push_back(predict_update(i_hood));
            if (i_out_valid && i_ready) begin
                if (expected_pixels.size() == 0) begin
                    $error("updated_value: unexpected word, actual %0d", i_updated_value);
                    fail_count++;
                end else begin
                    want = expected_pixels.pop_front();
                    if (want !== i_updated_value) begin
                        $error("updated_value: expected %0d, actual %0d", want, i_updated_value);
                        fail_count++;
                    end
                end
            end
        end
    end
endmodule

>>> dv/tb_nonconvex_diffusion_pixel_update_unit.sv
// Testbench top for the diffusion pixel update unit: drives neighbourhood words with random
// idling and stalls, and gives the verdict. Depends on nvd_pkg and nvd_update_checker.
module tb_nonconvex_diffusion_pixel_update_unit;
    timeunit 1ns;
    timeprecision 1ps;
    import nvd_pkg::*;

    logic             i_clk = 0;
    logic             i_rst_n = 0;
    logic             in_valid = 0;
    logic             out_ready = 0;
    logic             dut_ready;
    logic             dut_valid;
    logic [PIX_W-1:0] updated;
    t_hood            hood = '0;
    int               fail_count;
    int               pending;
    int               send_idle_pct = 0;
    int               recv_stall_pct = 0;

    nonconvex_diffusion_pixel_update_unit i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(in_valid), .o_ready(dut_ready),
        .i_center(hood.center), .i_north(hood.north), .i_south(hood.south),
        .i_west(hood.west), .i_east(hood.east), .i_north_west(hood.north_west),
        .i_north_east(hood.north_east), .i_south_west(hood.south_west),
        .i_south_east(hood.south_east), .i_noisy_center(hood.noisy_center),
        .o_valid(dut_valid), .i_ready(out_ready), .o_updated_value(updated)
    );

    nvd_update_checker i_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(in_valid), .i_in_ready(dut_ready),
        .i_hood(hood), .i_out_valid(dut_valid), .i_ready(out_ready),
        .i_updated_value(updated), .o_fail_count(fail_count), .o_pending(pending)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    // Receiver stalls at the falling edge, according to the current phase.
    always @(negedge i_clk) out_ready <= ($urandom_range(99) >= recv_stall_pct);

    // Offer one word, idling first if asked, and hold it until it is taken.
    // Valid is only dropped while idling, so a word that follows directly keeps it high.
    task automatic send_word(input t_hood w);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(negedge i_clk);
        end
        hood     <= w;
        in_valid <= 1'b1;
        do @(posedge i_clk); while (!dut_ready);
        @(negedge i_clk);
    endtask

    // Random neighbourhood: a third fully random, else a patch near a base, mostly smooth.
    function automatic t_hood random_hood();
        t_hood h;
        int    base, spread;
        if ($urandom_range(2) == 0) begin
            h = 80'({$urandom, $urandom, $urandom});
        end else begin
            base   = $urandom_range(255);
            spread = ($urandom_range(3) == 0) ? 255 : $urandom_range(24);
            for (int i = 0; i < 10; i++)
                h[i*PIX_W +: PIX_W] = 8'((base + $urandom_range(2 * spread) - spread) & 255);
        end
        return h;
    endfunction

    initial begin
        t_hood w;
        int    idle_sets[4][2] = '{'{0, 0}, '{85, 0}, '{0, 85}, '{36, 36}};
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        // Directed: flat patches at the extremes, single edges, maximum gradients.
        send_word('0);
        send_word('1);
        send_word({10{8'd128}});
        w = {10{8'd0}};  w.center = 8'd255; send_word(w);
        w = {10{8'd255}}; w.center = 8'd0; send_word(w);
        w = {10{8'd255}}; w.noisy_center = 8'd0; send_word(w);
        w = {10{8'd0}};  w.noisy_center = 8'd255; send_word(w);
        w = '0; w.north = 8'd255; w.north_east = 8'd255; w.north_west = 8'd255; send_word(w);
        w = '0; w.east = 8'd255; w.north_east = 8'd255; w.south_east = 8'd255; send_word(w);
        w = '0; w.south_east = 8'd255; w.north_west = 8'd255; send_word(w);
        w = {10{8'hAA}}; send_word(w);
        w = {10{8'h55}}; send_word(w);
        for (int i = 0; i < 10; i++) begin
            w = '0; w[i*PIX_W +: PIX_W] = 8'd255; send_word(w);
        end
        // Random words across the idling phases.
        for (int p = 0; p < 5; p++) begin
            send_idle_pct  = idle_sets[p % 4][0];
            recv_stall_pct = idle_sets[p % 4][1];
            for (int i = 0; i < 140; i++) send_word(random_hood());
        end
        in_valid       <= 1'b0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        while (pending != 0) @(posedge i_clk);
        repeat (PIPE_LAST + 10) @(posedge i_clk);
        if (fail_count == 0)
            $display("tb_nonconvex_diffusion_pixel_update_unit passed");
        else
            $display("tb_nonconvex_diffusion_pixel_update_unit failed");
        $finish;
    end

    initial begin
        #5ms;
        $display("tb_nonconvex_diffusion_pixel_update_unit failed");
        $finish;
    end
endmodule

>>> nonconvex_diffusion_pixel_update_unit.f
rtl/nvd_pkg.sv
rtl/nvd_diffusivity.sv
rtl/nvd_pair_divider.sv
rtl/nvd_blend.sv
rtl/nonconvex_diffusion_pixel_update_unit.sv
dv/nvd_update_checker.sv
dv/tb_nonconvex_diffusion_pixel_update_unit.sv
